>>> rtl/edfs_pkg.sv
`default_nettype none

package edfs_pkg;

    localparam int MAX_TASKS = 8;
    localparam int TASK_AW   = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int TASK_CW   = $clog2(MAX_TASKS + 1);

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_TASK_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_LIMIT = 1'd1;

    localparam logic [3:0]  TASK_COUNT_RST = 4'd1;
    localparam logic [31:0] TIME_LIMIT_RST = 32'd20;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [2:0]  task_index;
        logic [15:0] task_burst;
        logic [15:0] task_deadline;
        logic [15:0] task_period;
    } t_in;

    typedef struct packed {
        logic [2:0]  chosen_task;
        logic        ran;
        logic [31:0] clock_now;
        logic [31:0] chosen_new_deadline;
        logic [15:0] chosen_runs;
        logic        finished;
    } t_out;

    typedef struct packed {
        logic [3:0]  task_count;
        logic [31:0] time_limit;
    } t_cfg;

    typedef struct packed {
        logic [15:0] burst;
        logic [15:0] period;
        logic [31:0] deadline;
        logic [31:0] mark;
        logic [15:0] runs;
    } t_entry;

    typedef struct packed {
        logic               we;
        logic [TASK_AW-1:0] addr;
        t_entry             data;
    } t_ram_wr;

    typedef struct packed {
        logic               re;
        logic [TASK_AW-1:0] addr;
    } t_ram_rd;

    function automatic logic [31:0] sat_add32(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/edfs_ram.sv
`default_nettype none

module edfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                        i_wdata,
    input  wire logic                                    i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/edfs_ctrl.sv
`default_nettype none

module edfs_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire edfs_pkg::t_in     i_in_data,
    input  wire edfs_pkg::t_cfg    i_cfg,
    output logic                   o_res_valid,
    input  wire logic              i_res_take,
    output edfs_pkg::t_out         o_res,
    output edfs_pkg::t_ram_wr      o_ram_wr,
    output edfs_pkg::t_ram_rd      o_ram_rd,
    input  wire edfs_pkg::t_entry  i_ram_rdata
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_UPDATE = 4'b0100,
        ST_EMIT   = 4'b1000
    } t_state;

    t_state                         r_state, n_state;
    logic [31:0]                    r_clock, n_clock;
    logic [edfs_pkg::TASK_CW-1:0]   r_next, n_next;
    logic [edfs_pkg::TASK_CW-1:0]   r_n, n_n;
    logic [edfs_pkg::TASK_AW-1:0]   r_rd_idx, n_rd_idx;
    logic [edfs_pkg::TASK_AW-1:0]   r_best_idx, n_best_idx;
    edfs_pkg::t_entry               r_best, n_best;
    edfs_pkg::t_out                 r_res, n_res;

    logic                           accept;
    logic                           idx_ok;
    logic [edfs_pkg::TASK_CW-1:0]   n_sel;
    logic                           better;
    logic                           eligible;
    logic [31:0]                    clk_sum;
    logic [31:0]                    dl_sum;
    logic [31:0]                    mark_sum;
    logic [15:0]                    runs_inc;
    logic [31:0]                    upd_clock;
    logic [31:0]                    load_clock;

    assign accept = i_in_valid && (r_state == ST_IDLE);
    assign idx_ok = (32'(i_in_data.task_index) < 32'(edfs_pkg::MAX_TASKS));

    // clamp the entry count to the table, and treat zero as one entry
    always_comb begin
        if (32'(i_cfg.task_count) > 32'(edfs_pkg::MAX_TASKS)) begin
            n_sel = edfs_pkg::TASK_CW'(edfs_pkg::MAX_TASKS);
        end else if (i_cfg.task_count == 4'd0) begin
            n_sel = edfs_pkg::TASK_CW'(1);
        end else begin
            n_sel = edfs_pkg::TASK_CW'(i_cfg.task_count);
        end
    end

    // tie goes to the later entry
    assign better = (r_rd_idx == '0) || (i_ram_rdata.deadline <= r_best.deadline);

    assign eligible  = (r_best.mark >= r_clock);
    assign clk_sum   = edfs_pkg::sat_add32(r_clock, 32'(r_best.burst));
    assign dl_sum    = edfs_pkg::sat_add32(r_best.deadline, 32'(r_best.period));
    assign mark_sum  = edfs_pkg::sat_add32(r_best.mark, 32'(r_best.period));
    assign runs_inc  = (r_best.runs == 16'hFFFF) ? r_best.runs : r_best.runs + 16'd1;
    assign upd_clock = eligible ? clk_sum : r_clock;
    assign load_clock = idx_ok ? 32'd0 : r_clock;

    always_comb begin
        n_state    = r_state;
        n_clock    = r_clock;
        n_next     = r_next;
        n_n        = r_n;
        n_rd_idx   = r_rd_idx;
        n_best_idx = r_best_idx;
        n_best     = r_best;
        n_res      = r_res;
        o_ram_wr   = '0;
        o_ram_rd   = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_in_data.cmd == edfs_pkg::CMD_LOAD) begin
                        o_ram_wr.we            = idx_ok;
                        o_ram_wr.addr          = edfs_pkg::TASK_AW'(i_in_data.task_index);
                        o_ram_wr.data.burst    = i_in_data.task_burst;
                        o_ram_wr.data.period   = i_in_data.task_period;
                        o_ram_wr.data.deadline = 32'(i_in_data.task_deadline);
                        o_ram_wr.data.mark     = 32'(i_in_data.task_period);
                        o_ram_wr.data.runs     = 16'd0;
                        n_clock                = load_clock;
                        n_res.chosen_task      = i_in_data.task_index;
                        n_res.ran              = 1'b0;
                        n_res.clock_now        = load_clock;
                        n_res.chosen_new_deadline =
                            idx_ok ? 32'(i_in_data.task_deadline) : 32'd0;
                        n_res.chosen_runs      = 16'd0;
                        n_res.finished         = (load_clock >= i_cfg.time_limit);
                        n_state                = ST_EMIT;
                    end else if (r_clock >= i_cfg.time_limit) begin
                        n_res.chosen_task         = 3'd0;
                        n_res.ran                 = 1'b0;
                        n_res.clock_now           = r_clock;
                        n_res.chosen_new_deadline = 32'd0;
                        n_res.chosen_runs         = 16'd0;
                        n_res.finished            = 1'b1;
                        n_state                   = ST_EMIT;
                    end else begin
                        o_ram_rd.re   = 1'b1;
                        o_ram_rd.addr = '0;
                        n_rd_idx      = '0;
                        n_next        = edfs_pkg::TASK_CW'(1);
                        n_n           = n_sel;
                        n_state       = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (better) begin
                    n_best     = i_ram_rdata;
                    n_best_idx = r_rd_idx;
                end
                if (r_next < r_n) begin
                    o_ram_rd.re   = 1'b1;
                    o_ram_rd.addr = r_next[edfs_pkg::TASK_AW-1:0];
                    n_rd_idx      = r_next[edfs_pkg::TASK_AW-1:0];
                    n_next        = r_next + edfs_pkg::TASK_CW'(1);
                end else begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                o_ram_wr.we            = eligible;
                o_ram_wr.addr          = r_best_idx;
                o_ram_wr.data.burst    = r_best.burst;
                o_ram_wr.data.period   = r_best.period;
                o_ram_wr.data.deadline = dl_sum;
                o_ram_wr.data.mark     = mark_sum;
                o_ram_wr.data.runs     = runs_inc;
                n_clock                = upd_clock;
                n_res.chosen_task      = 3'(r_best_idx);
                n_res.ran              = eligible;
                n_res.clock_now        = upd_clock;
                n_res.chosen_new_deadline = eligible ? dl_sum : r_best.deadline;
                n_res.chosen_runs      = eligible ? runs_inc : r_best.runs;
                n_res.finished         = (upd_clock >= i_cfg.time_limit);
                n_state                = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_res_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_clock <= 32'd0;
        end else begin
            r_state <= n_state;
            r_clock <= n_clock;
        end
    end

    always_ff @(posedge i_clk) begin
        r_next     <= n_next;
        r_n        <= n_n;
        r_rd_idx   <= n_rd_idx;
        r_best_idx <= n_best_idx;
        r_best     <= n_best;
        r_res      <= n_res;
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_res_valid = (r_state == ST_EMIT);
    assign o_res       = r_res;

`ifndef SYNTHESIS
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_next <= r_n))
        else $error("scan pointer ran past the entry count");

    a_wr_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ram_wr.we |-> ((r_state == ST_UPDATE) || (r_state == ST_IDLE && i_in_valid)))
        else $error("table write outside load or update");

    a_upd_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPDATE) |-> ($past(r_state) == ST_SCAN))
        else $error("update entered without a scan");

    a_clock_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |=> $stable(r_clock))
        else $error("clock moved during scan");
`endif

endmodule

`default_nettype wire

>>> rtl/edf_task_scheduler.sv
`default_nettype none

// Earliest-deadline-first scheduler. Each input beat either loads one task
// entry (burst, first deadline, period; clears the scheduler clock) or runs
// one scheduling step, and each produces exactly one output beat. The task
// table sits in a single-port-read synchronous RAM, so a step scans the
// deadlines of the active entries one per cycle, counting a task_count of
// zero as one and anything above eight as eight; a load, or a step after
// the time limit, needs no scan and goes straight to its result. One item is
// in work at a time; the output register lets a new item start while the
// last result still waits to be taken. Entries selected by a step must have
// been loaded first.
module edf_task_scheduler (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire edfs_pkg::t_in                      i_in_data,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output edfs_pkg::t_out                          o_out_data,
    input  wire logic                               i_cfg_we,
    input  wire logic [edfs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [edfs_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    edfs_pkg::t_cfg     r_cfg;
    edfs_pkg::t_out     r_out;
    logic               r_out_valid;

    logic               in_ready;
    logic               res_valid;
    logic               out_free;
    edfs_pkg::t_out     res;
    edfs_pkg::t_ram_wr  ram_wr;
    edfs_pkg::t_ram_rd  ram_rd;
    edfs_pkg::t_entry   ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.task_count <= edfs_pkg::TASK_COUNT_RST;
            r_cfg.time_limit <= edfs_pkg::TIME_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                edfs_pkg::CFG_TASK_COUNT: r_cfg.task_count <= i_cfg_data[3:0];
                edfs_pkg::CFG_TIME_LIMIT: r_cfg.time_limit <= i_cfg_data[31:0];
                default: begin
                end
            endcase
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;

    // hold the beat until taken, refill as soon as the slot frees
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && out_free) begin
            r_out <= res;
        end
    end

    edfs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (i_in_data),
        .i_cfg       (r_cfg),
        .o_res_valid (res_valid),
        .i_res_take  (out_free),
        .o_res       (res),
        .o_ram_wr    (ram_wr),
        .o_ram_rd    (ram_rd),
        .i_ram_rdata (ram_rdata)
    );

    edfs_ram #(
        .WIDTH ($bits(edfs_pkg::t_entry)),
        .DEPTH (edfs_pkg::MAX_TASKS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_wr.we),
        .i_waddr (ram_wr.addr),
        .i_wdata (ram_wr.data),
        .i_re    (ram_rd.re),
        .i_raddr (ram_rd.addr),
        .o_rdata (ram_rdata)
    );

    assign o_in_stall  = !in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;

    import edfs_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 20;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in                   i_in_data;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_out                  o_out_data;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // Scheduler state as predicted from the accepted beats
    logic [15:0] burst_tab  [MAX_TASKS];
    logic [15:0] period_tab [MAX_TASKS];
    logic [31:0] dl_tab     [MAX_TASKS];
    logic [31:0] mark_tab   [MAX_TASKS];
    logic [15:0] runs_tab   [MAX_TASKS];
    logic [31:0] sched_now;
    logic [3:0]  count_reg;
    logic [31:0] limit_reg;

    t_out pending_reports[$];
    t_out want_report;
    int   fail_count  = 0;
    int   quiet_cycles = 0;
    int   hold_cycles = 0;
    bit   gaps_on     = 1'b1;
    bit   in_offer    = 1'b0;
    int   send_stretch = 0;
    bit   send_calm   = 1'b0;

    edf_task_scheduler i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [31:0] clamp_add(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    task automatic reset_schedule_model();
        for (int i = 0; i < MAX_TASKS; i++) begin
            burst_tab[i]  = '0;
            period_tab[i] = '0;
            dl_tab[i]     = '0;
            mark_tab[i]   = '0;
            runs_tab[i]   = '0;
        end
        sched_now = '0;
        count_reg = TASK_COUNT_RST;
        limit_reg = TIME_LIMIT_RST;
    endtask

    function automatic t_out edf_advance(t_in beat);
        t_out r;
        int   span;
        int   best;
        r = '0;
        if (beat.cmd == CMD_LOAD) begin
            r.chosen_task = beat.task_index;
            burst_tab[beat.task_index]  = beat.task_burst;
            period_tab[beat.task_index] = beat.task_period;
            dl_tab[beat.task_index]     = {16'd0, beat.task_deadline};
            mark_tab[beat.task_index]   = {16'd0, beat.task_period};
            runs_tab[beat.task_index]   = '0;
            sched_now = '0;
            r.chosen_new_deadline = {16'd0, beat.task_deadline};
        end else if (sched_now < limit_reg) begin
            span = (count_reg > MAX_TASKS) ? MAX_TASKS : count_reg;
            best = 0;
            for (int i = 1; i < span; i++) begin
                if (dl_tab[i] <= dl_tab[best]) begin
                    best = i;
                end
            end
            r.chosen_task = 3'(best);
            if (mark_tab[best] >= sched_now) begin
                sched_now      = clamp_add(sched_now, {16'd0, burst_tab[best]});
                dl_tab[best]   = clamp_add(dl_tab[best], {16'd0, period_tab[best]});
                mark_tab[best] = clamp_add(mark_tab[best], {16'd0, period_tab[best]});
                if (runs_tab[best] != 16'hFFFF) begin
                    runs_tab[best] = runs_tab[best] + 16'd1;
                end
                r.ran = 1'b1;
            end
            r.chosen_new_deadline = dl_tab[best];
            r.chosen_runs         = runs_tab[best];
        end
        r.clock_now = sched_now;
        r.finished  = (sched_now >= limit_reg);
        return r;
    endfunction

    // Mostly no gap, some short ones, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end else begin
            return $urandom_range(8, 40);
        end
    endfunction

    function automatic t_in load_beat(logic [2:0] idx, logic [15:0] burst,
                                      logic [15:0] dl, logic [15:0] per);
        t_in b;
        b.cmd           = CMD_LOAD;
        b.task_index    = idx;
        b.task_burst    = burst;
        b.task_deadline = dl;
        b.task_period   = per;
        return b;
    endfunction

    function automatic t_in random_load(logic [2:0] idx);
        logic [15:0] burst;
        logic [15:0] dl;
        logic [15:0] per;
        burst = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 24));
        dl    = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 60));
        case ($urandom_range(0, 9))
            0: begin
                per = 16'd0;
            end
            1, 2: begin
                per = 16'($urandom);
            end
            default: begin
                per = 16'($urandom_range(1, 24));
            end
        endcase
        return load_beat(idx, burst, dl, per);
    endfunction

    // A step ignores the other fields; fill them with noise
    function automatic t_in random_step();
        t_in         b;
        logic [63:0] noise;
        noise         = {$urandom, $urandom};
        b             = noise[$bits(t_in)-1:0];
        b.cmd         = CMD_STEP;
        return b;
    endfunction

    task automatic send_beat(input t_in beat);
        int n;
        if (send_stretch == 0) begin
            send_stretch = $urandom_range(10, 60);
            send_calm    = ($urandom_range(0, 3) == 0);
        end
        send_stretch--;
        n = (gaps_on && !send_calm) ? gap_len() : 0;
        if (n > 0) begin
            if (in_offer) begin
                i_in_valid <= 1'b0;
                in_offer = 1'b0;
            end
            repeat (n) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        in_offer = 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_reports.push_back(edf_advance(beat));
    endtask

    task automatic wait_drain();
        if (in_offer) begin
            i_in_valid <= 1'b0;
            in_offer = 1'b0;
        end
        while (pending_reports.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_regs(input logic [3:0] cnt, input logic [31:0] lim);
        wait_drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_TASK_COUNT;
        i_cfg_data  <= {28'($urandom), cnt};
        @(posedge i_clk);
        i_cfg_index <= CFG_TIME_LIMIT;
        i_cfg_data  <= lim;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        count_reg = cnt;
        limit_reg = lim;
    endtask

    function automatic logic [3:0] pick_count();
        case ($urandom_range(0, 4))
            0: return 4'd0;
            1: return 4'd1;
            2: return 4'd8;
            3: return 4'd15;
            default: return 4'($urandom_range(0, 15));
        endcase
    endfunction

    function automatic logic [31:0] pick_limit();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'd20;
            2: return 32'hFFFF_FFFF;
            3: return $urandom;
            default: return $urandom_range(1, 400);
        endcase
    endfunction

    task automatic test_directed();
        gaps_on = 1'b1;
        // Fill the whole table before any step reads it
        send_beat(load_beat(3'd0, 16'd6, 16'd0, 16'd4));
        send_beat(load_beat(3'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_beat(load_beat(3'd2, 16'd0, 16'd9, 16'd1));
        send_beat(load_beat(3'd3, 16'd2, 16'd0, 16'd0));
        for (int i = 4; i < MAX_TASKS; i++) begin
            send_beat(random_load(3'(i)));
        end
        // Burst longer than period: task 0 runs three times, then falls behind
        repeat (5) send_beat(random_step());
        set_regs(4'd8, 32'hFFFF_FFFF);
        send_beat(load_beat(3'd3, 16'd2, 16'd0, 16'd0));
        repeat (2) send_beat(random_step());
        set_regs(4'd0, 32'd20);
        send_beat(load_beat(3'd0, 16'd1, 16'd5, 16'd5));
        send_beat(random_step());
        set_regs(4'd15, 32'd0);
        send_beat(load_beat(3'd1, 16'd0, 16'd0, 16'd1));
        send_beat(random_step());
        // Equal deadlines: higher index wins
        set_regs(4'd3, 32'd100);
        send_beat(load_beat(3'd1, 16'd1, 16'd5, 16'd3));
        send_beat(load_beat(3'd2, 16'd1, 16'd5, 16'd3));
        send_beat(load_beat(3'd0, 16'd1, 16'd5, 16'd3));
        repeat (2) send_beat(random_step());
    endtask

    task automatic test_backpressure();
        gaps_on = 1'b1;
        set_regs(4'd8, 32'hFFFF_FFFF);
        for (int i = 0; i < MAX_TASKS; i++) begin
            send_beat(random_load(3'(i)));
        end
        hold_cycles = 300;
        repeat (16) send_beat(random_step());
        wait_drain();
        repeat (8) send_beat(random_step());
    endtask

    task automatic test_random();
        int sent;
        sent = 0;
        gaps_on = 1'b1;
        while (sent < 320) begin
            set_regs(pick_count(), pick_limit());
            repeat ($urandom_range(1, 8)) begin
                send_beat(random_load(3'($urandom_range(0, 7))));
                sent++;
            end
            repeat ($urandom_range(5, 30)) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_beat(random_load(3'($urandom_range(0, 7))));
                end else begin
                    send_beat(random_step());
                end
                sent++;
            end
        end
    endtask

    // One task with burst and period near the 16-bit top: the sums carry past
    // 16 bits, and the clock crosses the time limit partway through a burst
    task automatic test_wide_sums();
        gaps_on = 1'b0;
        set_regs(4'd1, 32'h0005_0000);
        send_beat(load_beat(3'd0, 16'hFFFE, 16'hFFFF, 16'hFFFF));
        while (sched_now < limit_reg) send_beat(random_step());
        repeat (2) send_beat(random_step());
        set_regs(4'd1, 32'hFFFF_FFFF);
        send_beat(load_beat(3'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        repeat (20) send_beat(random_step());
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_reports.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, got %p",
                         $time, o_out_data);
                fail_count++;
            end else begin
                want_report = pending_reports.pop_front();
                check_field("chosen_task", want_report.chosen_task, o_out_data.chosen_task);
                check_field("ran", want_report.ran, o_out_data.ran);
                check_field("clock_now", want_report.clock_now, o_out_data.clock_now);
                check_field("chosen_new_deadline", want_report.chosen_new_deadline,
                            o_out_data.chosen_new_deadline);
                check_field("chosen_runs", want_report.chosen_runs, o_out_data.chosen_runs);
                check_field("finished", want_report.finished, o_out_data.finished);
            end
        end
    end

    initial begin : out_stall_drive
        int n;
        int stretch;
        bit calm;
        stretch = 0;
        calm    = 1'b0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stretch == 0) begin
                stretch = $urandom_range(20, 120);
                calm    = ($urandom_range(0, 3) == 0);
            end
            stretch--;
            n = 0;
            if (hold_cycles > 0) begin
                n = hold_cycles;
                hold_cycles = 0;
            end else if (gaps_on && !calm) begin
                n = gap_len();
            end
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_TASK_COUNT;
        i_cfg_data  <= '0;
        reset_schedule_model();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_backpressure();
        test_random();
        test_wide_sums();

        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

>>> edf_task_scheduler.f
rtl/edfs_pkg.sv
rtl/edfs_ram.sv
rtl/edfs_ctrl.sv
rtl/edf_task_scheduler.sv
tb/sv/testbench.sv
